>>> rtl/timed_input_sequence_matcher_defines.svh
// Assertion macros shared by the matcher RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef TIMED_INPUT_SEQUENCE_MATCHER_DEFINES_SVH
`define TIMED_INPUT_SEQUENCE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TISM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TISM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tism_pkg.sv
// Shared constants, types and helpers for the timed input sequence matcher.
// No dependencies; used by tism_history and the top level.
package tism_pkg;

  // Parameter defaults
  localparam int NUM_COMMANDS_DEF  = 4;
  localparam int HISTORY_DEPTH_DEF = 32;
  localparam int MAX_SEQUENCE_DEF  = 8;

  // Command register layout
  localparam int CFG_COUNT  = 4;   // commands that have a register
  localparam int REG_CODES  = 8;   // direction codes a register holds
  localparam int CMD_W      = 42;
  localparam int CODE_W     = 4;
  localparam int LEN_LSB    = 0;
  localparam int LEN_W      = 4;
  localparam int LIM_LSB    = 4;
  localparam int LIM_W      = 6;
  localparam int CODE_LSB   = 10;
  localparam int CODE_SEL_W = 3;

  // Register port
  localparam int DATA_W      = 64;
  localparam int PADDR_W     = 5;
  localparam int CFG_IDX_LSB = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CMD_IDX_W   = 3;  // wide enough for up to 8 commands

  // History memory control from the sequencer
  typedef struct packed {
    logic wr;   // write the new frame
    logic clr;  // forget every stored frame
  } hist_ctl_t;

  // Direction code of element k, held in code slot k-1 (k counts elements from 1)
  function automatic logic [CODE_W-1:0] cmd_code(logic [CMD_W-1:0] cmd,
                                                 logic [LEN_W-1:0] k);
    logic [CODE_SEL_W-1:0] sel;
    sel = CODE_SEL_W'(k - 4'd1);
    return cmd[CODE_LSB + CODE_W * sel +: CODE_W];
  endfunction

endpackage

>>> rtl/tism_history.sv
// Frame history ring: code memory with a valid bit per entry.
// Depends on tism_pkg for hist_ctl_t and the code width.
module tism_history #(
  parameter int DEPTH = tism_pkg::HISTORY_DEPTH_DEF,
  parameter int AW    = $clog2(tism_pkg::HISTORY_DEPTH_DEF)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tism_pkg::hist_ctl_t         ctl,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tism_pkg::CODE_W-1:0] wr_code,
  input  logic [AW-1:0]               rd_addr,
  output logic [tism_pkg::CODE_W-1:0] rd_code
);
  import tism_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [CODE_W-1:0] rd_data;
  logic              rd_valid;

  // Code storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_code;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits: cleared all at once on reset or on a match
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctl.wr) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  // Entry never written since the last clear reads as neutral
  assign rd_code = rd_valid ? rd_data : '0;

endmodule

>>> rtl/timed_input_sequence_matcher.sv
// Timed input sequence matcher: one frame per transaction, one result per frame. Per tried
// command the search loads the command, then reads and compares one history frame at a time,
// comparing each further element tried against the same frame, and the result may then wait
// on out_stall; in_stall holds off new frames until the result is loaded. The single history
// read port and the one code comparator set the pace of the search. History entries are
// cleared instantly through valid bits, so no clearing pass follows reset. Commands sit at
// byte addresses 0, 8, 16, 24 (64-bit data).
`include "timed_input_sequence_matcher_defines.svh"

module timed_input_sequence_matcher #(
  parameter int NUM_COMMANDS  = tism_pkg::NUM_COMMANDS_DEF,
  parameter int HISTORY_DEPTH = tism_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_SEQUENCE  = tism_pkg::MAX_SEQUENCE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // frame input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         up,
  input  logic                         down,
  input  logic                         left,
  input  logic                         right,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         matched,
  output logic [1:0]                   command_index,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tism_pkg::PADDR_W-1:0] paddr,
  input  logic [tism_pkg::DATA_W-1:0]  pwdata,
  output logic [tism_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import tism_pkg::*;

  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int DW      = $clog2(HISTORY_DEPTH + 1);
  localparam int CW      = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;
  localparam int SEQ_MAX = (MAX_SEQUENCE < REG_CODES) ? MAX_SEQUENCE : REG_CODES;
  localparam int KW      = $clog2(SEQ_MAX + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_READ = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [CMD_W-1:0]  cmd_reg [CFG_COUNT];
  logic [CW-1:0]     cmd_idx, cmd_idx_next;
  logic [KW-1:0]     len_left, len_left_next;
  logic [DW-1:0]     back, back_next;
  logic [DW-1:0]     limit_q, limit_q_next;
  logic              hit, hit_next;
  logic [AW-1:0]     wp;

  logic              in_accept, out_load, cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CMD_IDX_W-1:0] idx_ext;
  logic [CMD_W-1:0]  cmd_cur;
  logic [LEN_W-1:0]  cmd_len;
  logic [LIM_W-1:0]  cmd_lim;
  logic [KW-1:0]     len_c;
  logic [DW-1:0]     lim_c;
  logic [CODE_W-1:0] elem_code, rd_code;
  logic [AW:0]       wp_x, back_x, pos_full;
  logic [AW-1:0]     rd_addr;
  logic              last_cmd;
  hist_ctl_t         hctl;

  // Register port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_IDX_LSB +: CFG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = {{(DATA_W - CMD_W){1'b0}}, cmd_reg[cfg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        cmd_reg[i] <= '0;
      end
    end else if (cfg_wr && (32'(cfg_idx) < NUM_COMMANDS)) begin
      cmd_reg[cfg_idx] <= pwdata[CMD_W-1:0];
    end
  end

  // Current command fields, clamped; commands without a register read as zero
  assign idx_ext = CMD_IDX_W'(cmd_idx);
  assign cmd_cur = (idx_ext < CMD_IDX_W'(CFG_COUNT)) ? cmd_reg[idx_ext[CFG_IDX_W-1:0]]
                                                      : '0;
  assign cmd_len = cmd_cur[LEN_LSB +: LEN_W];
  assign cmd_lim = cmd_cur[LIM_LSB +: LIM_W];
  assign len_c   = (cmd_len > LEN_W'(SEQ_MAX)) ? KW'(SEQ_MAX) : KW'(cmd_len);
  assign lim_c   = (cmd_lim > LIM_W'(HISTORY_DEPTH)) ? DW'(HISTORY_DEPTH) : DW'(cmd_lim);
  assign elem_code = cmd_code(cmd_cur, LEN_W'(len_left));
  assign last_cmd  = (cmd_idx == CW'(NUM_COMMANDS - 1));

  // Ring position of the frame back frames behind the newest one
  assign wp_x     = {1'b0, wp};
  assign back_x   = (AW + 1)'(back);
  assign pos_full = (wp_x >= back_x) ? (wp_x - back_x)
                                     : (wp_x + (AW + 1)'(HISTORY_DEPTH) - back_x);
  assign rd_addr  = pos_full[AW-1:0];

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // Sequencer: a single comparator checks each element against the registered history read
  always_comb begin
    state_next    = state;
    cmd_idx_next  = cmd_idx;
    len_left_next = len_left;
    back_next     = back;
    limit_q_next  = limit_q;
    hit_next      = hit;
    hctl.wr       = 1'b0;
    hctl.clr      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          hctl.wr      = 1'b1;
          cmd_idx_next = '0;
          hit_next     = 1'b0;
          state_next   = S_LOAD;
        end
      end
      S_LOAD: begin
        len_left_next = len_c;
        limit_q_next  = lim_c;
        back_next     = '0;
        if (len_c == '0) begin
          // empty command matches at once
          hit_next   = 1'b1;
          hctl.clr   = 1'b1;
          state_next = S_DONE;
        end else if (lim_c == '0) begin
          if (last_cmd) begin
            state_next = S_DONE;
          end else begin
            cmd_idx_next = cmd_idx + 1'b1;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (rd_code == elem_code) begin
          if (len_left == KW'(1)) begin
            hit_next   = 1'b1;
            hctl.clr   = 1'b1;
            state_next = S_DONE;
          end else begin
            // same frame may also serve the earlier element
            len_left_next = len_left - 1'b1;
          end
        end else if ((DW + 1)'(back) + 1'b1 >= (DW + 1)'(limit_q)) begin
          if (last_cmd) begin
            state_next = S_DONE;
          end else begin
            cmd_idx_next = cmd_idx + 1'b1;
            state_next   = S_LOAD;
          end
        end else begin
          back_next  = back + 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        wp <= (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_idx  <= cmd_idx_next;
    len_left <= len_left_next;
    back     <= back_next;
    limit_q  <= limit_q_next;
    hit      <= hit_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      matched       <= hit;
      command_index <= hit ? 2'(cmd_idx) : 2'd0;
    end
  end

  tism_history #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_history (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .wr_addr (wp),
    .wr_code ({right, left, down, up}),
    .rd_addr (rd_addr),
    .rd_code (rd_code)
  );

  // Checks
  `TISM_ASSERT_NEXT(a_accept_starts, in_accept, state == S_LOAD, "accept did not start a search")
  `TISM_ASSERT_IMPL(a_cmp_window, state == S_CMP, back < limit_q && len_left != '0, "bad compare")
  `TISM_ASSERT_IMPL(a_idx_on_miss, out_valid && !matched, command_index == 2'd0, "stray index")

endmodule
